### design/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SHA_ASSERT_CLK(lbl, clk_sig, rst_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error(msg);

// Same, on the clk and rst_n of the enclosing module.
`define SHA_ASSERT(lbl, prop, msg) \
    `SHA_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

### design/sha256_pkg.sv
`timescale 1ns / 1ps

package sha256_pkg;

    localparam int WordBits   = 32;
    localparam int BlockWords = 16;
    localparam int ChainWords = 8;
    localparam int CountBits  = 61;
    localparam int LenBits    = 64;

    typedef logic [WordBits-1:0] word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_UPDATE,
        ST_OUTPUT
    } state_t;

    localparam logic [7:0] PadMarker  = 8'h80;
    localparam logic [5:0] LenStart   = 6'd56;
    localparam logic [5:0] LastByte   = 6'd63;
    localparam logic [5:0] LastRound  = 6'd63;
    localparam logic [2:0] LastWord   = 3'd7;

    localparam word_t ChainInit [ChainWords] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

### design/sha256_ifs.sv
`timescale 1ns / 1ps

interface sha256_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_valid,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input end_of_message, output ready);
endinterface

interface sha256_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

### design/sha256_message_hasher_core.sv
`timescale 1ns / 1ps
// Channel  Side  Words carry                                Handshake
// msg      in    data_byte, byte_valid, end_of_message      valid / ready
// digest   out   digest_word, word_index, last_word         valid / ready
//
// A byte that neither completes a block nor ends the message keeps msg.ready high.
// The 64th byte of a block starts the rounds in the shared round unit, then the
// result is folded into the chain words; msg.ready is low meanwhile.
// End of message shifts padding and length through the same path in one byte
// per cycle, save while compressing (up to two blocks), then offers the eight
// digest words, one per accepted word. Reset is asynchronous and loads the initial chain words.
module sha256_message_hasher_core import sha256_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    sha256_byte_if.sink     msg,
    sha256_digest_if.source digest
);

    state_t               state_reg, state_next;
    word_t                chain_reg [ChainWords];
    word_t                sched_reg [BlockWords];
    word_t                vars_reg  [ChainWords];
    logic [5:0]           fill_reg;
    logic [CountBits-1:0] count_reg;
    logic [CountBits-1:0] count_next;
    logic [LenBits-1:0]   len_reg;
    logic [5:0]           round_reg;
    logic [2:0]           out_idx_reg;
    logic                 in_pad_reg;
    logic                 marker_done_reg;
    logic                 spill_reg;
    logic                 final_reg;

    logic  msg_fire;
    logic  digest_fire;
    logic  shift_en;
    logic  len_zone;
    logic  block_full;
    logic  [7:0] shift_byte;
    word_t t1, t2, w_new;

    assign msg.ready   = (state_reg == ST_IDLE);
    assign digest.valid = (state_reg == ST_OUTPUT);
    assign msg_fire    = msg.valid & msg.ready;
    assign digest_fire = digest.valid & digest.ready;

    assign digest.digest_word = chain_reg[out_idx_reg];
    assign digest.word_index  = out_idx_reg;
    assign digest.last_word   = (out_idx_reg == LastWord);

    assign count_next = count_reg + CountBits'(msg.byte_valid);

    // Length bytes go only into the block that holds the marker below byte 56,
    // or into the zero block that follows a spill.
    assign len_zone = marker_done_reg && !spill_reg && (fill_reg >= LenStart);

    always_comb
    begin
        shift_en   = 1'b0;
        shift_byte = msg.data_byte;
        case (state_reg)
            ST_IDLE:
            begin
                shift_en   = msg_fire & msg.byte_valid;
                shift_byte = msg.data_byte;
            end
            ST_PAD:
            begin
                shift_en = 1'b1;
                if (!marker_done_reg)
                    shift_byte = PadMarker;
                else if (len_zone)
                    shift_byte = len_reg[LenBits-1 -: 8];
                else
                    shift_byte = 8'h00;
            end
            default:
            begin
                shift_en   = 1'b0;
                shift_byte = msg.data_byte;
            end
        endcase
    end

    assign block_full = shift_en && (fill_reg == LastByte);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (msg_fire)
                begin
                    if (block_full)
                        state_next = ST_ROUND;
                    else if (msg.end_of_message)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (block_full)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (round_reg == LastRound)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (final_reg)
                    state_next = ST_OUTPUT;
                else if (in_pad_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_OUTPUT:
            begin
                if (digest_fire && digest.last_word)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // One compression round and one schedule step per cycle.
    always_comb
    begin
        t1 = vars_reg[7] + big_sigma1(vars_reg[4])
           + ((vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]))
           + RoundK[round_reg] + sched_reg[0];
        t2 = big_sigma0(vars_reg[0])
           + ((vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
              ^ (vars_reg[1] & vars_reg[2]));
        w_new = small_sigma1(sched_reg[14]) + sched_reg[9]
              + small_sigma0(sched_reg[1]) + sched_reg[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            fill_reg        <= '0;
            count_reg       <= '0;
            round_reg       <= '0;
            out_idx_reg     <= '0;
            in_pad_reg      <= 1'b0;
            marker_done_reg <= 1'b0;
            spill_reg       <= 1'b0;
            final_reg       <= 1'b0;
            for (int i = 0; i < ChainWords; i++)
                chain_reg[i] <= ChainInit[i];
        end
        else
        begin
            state_reg <= state_next;

            if (shift_en)
                fill_reg <= fill_reg + 6'd1;

            if (msg_fire && msg.byte_valid)
                count_reg <= count_next;

            if (msg_fire && msg.end_of_message)
                in_pad_reg <= 1'b1;

            if (state_reg == ST_PAD && !marker_done_reg)
                marker_done_reg <= 1'b1;

            if (block_full)
                spill_reg <= 1'b0;
            else if (state_reg == ST_PAD && !marker_done_reg && fill_reg >= LenStart)
                spill_reg <= 1'b1;

            if (block_full && state_reg == ST_PAD && marker_done_reg && !spill_reg)
                final_reg <= 1'b1;

            if (block_full)
                round_reg <= '0;
            else if (state_reg == ST_ROUND)
                round_reg <= round_reg + 6'd1;

            if (state_reg == ST_UPDATE)
            begin
                for (int i = 0; i < ChainWords; i++)
                    chain_reg[i] <= chain_reg[i] + vars_reg[i];
            end

            if (digest_fire)
            begin
                out_idx_reg <= out_idx_reg + 3'd1;
                if (digest.last_word)
                begin
                    for (int i = 0; i < ChainWords; i++)
                        chain_reg[i] <= ChainInit[i];
                    count_reg       <= '0;
                    in_pad_reg      <= 1'b0;
                    marker_done_reg <= 1'b0;
                    spill_reg       <= 1'b0;
                    final_reg       <= 1'b0;
                end
            end
        end
    end

    // Block bytes shift in big-endian through the schedule line, which then
    // rolls one word per round during compression.
    always_ff @(posedge clk)
    begin
        if (msg_fire && msg.end_of_message)
            len_reg <= {count_next, 3'b000};
        else if (state_reg == ST_PAD && len_zone)
            len_reg <= {len_reg[LenBits-9:0], 8'h00};

        if (shift_en)
        begin
            for (int i = 0; i < BlockWords - 1; i++)
                sched_reg[i] <= {sched_reg[i][23:0], sched_reg[i+1][31:24]};
            sched_reg[BlockWords-1] <= {sched_reg[BlockWords-1][23:0], shift_byte};
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < BlockWords - 1; i++)
                sched_reg[i] <= sched_reg[i+1];
            sched_reg[BlockWords-1] <= w_new;
        end

        if (block_full)
        begin
            for (int i = 0; i < ChainWords; i++)
                vars_reg[i] <= chain_reg[i];
        end
        else if (state_reg == ST_ROUND)
        begin
            vars_reg[7] <= vars_reg[6];
            vars_reg[6] <= vars_reg[5];
            vars_reg[5] <= vars_reg[4];
            vars_reg[4] <= vars_reg[3] + t1;
            vars_reg[3] <= vars_reg[2];
            vars_reg[2] <= vars_reg[1];
            vars_reg[1] <= vars_reg[0];
            vars_reg[0] <= t1 + t2;
        end
    end

endmodule

### design/sha256_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sha256_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        msg_ready,
    input logic        dig_valid,
    input logic        dig_ready,
    input logic [31:0] dig_word,
    input logic [2:0]  dig_index,
    input logic        dig_last
);

    logic       dig_fire;
    logic [2:0] next_idx;

    assign dig_fire = dig_valid && dig_ready;
    assign next_idx = dig_index + 3'd1;

    // While digest words are offered, no message byte may be taken.
    `SHA_ASSERT(a_no_input_during_digest, dig_valid |-> !msg_ready,
                "byte taken during digest")

    // Digest words come out in order, one index per accepted word.
    `SHA_ASSERT(a_index_steps,
                dig_fire && !dig_last |=> dig_valid && dig_index == $past(next_idx),
                "digest index skipped")

    `SHA_ASSERT(a_last_on_seventh, dig_valid |-> (dig_last == (dig_index == 3'd7)),
                "last flag misplaced")

    // After the final word the block is ready for the next message.
    `SHA_ASSERT(a_ready_after_last, dig_fire && dig_last |=> msg_ready && !dig_valid,
                "not ready after digest")

    `SHA_ASSERT(a_stall_holds,
                dig_valid && !dig_ready |=> dig_valid && $stable(dig_word),
                "stalled digest word changed")

endmodule

bind sha256_message_hasher_core sha256_checker u_sha256_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .msg_ready (msg.ready),
    .dig_valid (digest.valid),
    .dig_ready (digest.ready),
    .dig_word  (digest.digest_word),
    .dig_index (digest.word_index),
    .dig_last  (digest.last_word)
);
